### src/srm_pkg.sv
package srm_pkg;

    localparam int OP_W      = 3;
    localparam int REG_IDX_W = 8;
    localparam int WORD_W    = 32;
    localparam int STATUS_W  = 3;

    localparam int REG_COUNT_DEF = 8;
    localparam int MEM_WORDS_DEF = 256;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MOV   = 3'd2,
        OP_LOAD  = 3'd3,
        OP_STORE = 3'd4,
        OP_START = 3'd5,
        OP_EXIT  = 3'd6,
        OP_DISC  = 3'd7
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_NOT_STARTED  = 3'd1,
        ST_BAD_REG      = 3'd2,
        ST_BAD_ADDR     = 3'd3,
        ST_DISC_REFUSED = 3'd4,
        ST_TERMINATE    = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_RD_B,
        S_WB,
        S_DONE
    } t_state;

endpackage

### src/srm_in_if.sv
interface srm_in_if import srm_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [OP_W-1:0]             op;
    logic [REG_IDX_W-1:0]        reg_dest;
    logic [REG_IDX_W-1:0]        reg_src;
    logic signed [WORD_W-1:0]    operand;

    modport source (output valid, op, reg_dest, reg_src, operand, input ready);
    modport sink   (input valid, op, reg_dest, reg_src, operand, output ready);
endinterface

### src/srm_out_if.sv
interface srm_out_if import srm_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [STATUS_W-1:0]         status;
    logic signed [WORD_W-1:0]    reg_value;
    logic signed [WORD_W-1:0]    pointer;
    logic                        is_running;

    modport source (output valid, status, reg_value, pointer, is_running, input ready);
    modport sink   (input valid, status, reg_value, pointer, is_running, output ready);
endinterface

### src/srm_ram.sv
module srm_ram import srm_pkg::*; #(
    parameter int WIDTH = WORD_W,
    parameter int DEPTH = REG_COUNT_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/small_register_machine_executor.sv
// Small register machine executor. Each input beat carries one decoded
// instruction; each produces exactly one result beat with the status, the
// value written to the destination register (zero if none), the instruction
// pointer and the running flag after the step. The register file and the data
// memory sit in two simple dual-port synchronous RAMs (one write port, one
// registered read port), so an instruction is a short read-modify-write
// sequence: ADD, SUB, MOV, LOAD and STORE go from accept to the next accept
// through check, read rd, read rs / memory word, write back, load the result
// register; a rejected instruction, DISC and a stopped EXIT go from check to
// the result register. START and a running EXIT zero both RAMs with a sweep
// of max(REG_COUNT, MEM_WORDS) entries, one per cycle, before their result
// appears. The same sweep runs after reset, and no beat is accepted until it
// finishes. A result waiting in the output register does not block the accept
// of the next instruction; only its completion waits for the slot to drain.
module small_register_machine_executor import srm_pkg::*; #(
    parameter int REG_COUNT = REG_COUNT_DEF,
    parameter int MEM_WORDS = MEM_WORDS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    srm_in_if.sink     i_in,
    srm_out_if.source  o_out
);

    localparam int REG_AW    = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int MEM_AW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int CLR_DEPTH = (REG_COUNT > MEM_WORDS) ? REG_COUNT : MEM_WORDS;
    localparam int CLR_AW    = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

    // sequencer and machine state
    t_state                r_state, n_state;
    logic [CLR_AW-1:0]     r_clr_cnt, n_clr_cnt;
    logic                  r_clr_resp, n_clr_resp;
    logic [WORD_W-1:0]     r_ip, n_ip;
    logic                  r_running, n_running;

    // latched instruction
    t_op                   r_op;
    logic [REG_IDX_W-1:0]  r_rd, r_rs;
    logic [WORD_W-1:0]     r_opnd;
    logic [WORD_W-1:0]     r_a, n_a;

    // pending result
    t_status               r_status, n_status;
    logic [WORD_W-1:0]     r_rval, n_rval;

    // output register
    logic                  r_out_valid, n_out_valid;
    t_status               r_out_status, n_out_status;
    logic [WORD_W-1:0]     r_out_rval, n_out_rval;
    logic [WORD_W-1:0]     r_out_ptr, n_out_ptr;
    logic                  r_out_run, n_out_run;

    // RAM ports
    logic                  reg_we, mem_we;
    logic [REG_AW-1:0]     reg_waddr, reg_raddr;
    logic [MEM_AW-1:0]     mem_waddr;
    logic [WORD_W-1:0]     reg_wdata, mem_wdata, reg_rdata, mem_rdata;

    // decode helpers
    logic                  in_acc;
    logic                  rd_bad, rs_bad, addr_bad, is_alu, is_mem;
    logic [WORD_W:0]       disc_diff;
    logic                  disc_refuse;
    logic                  out_free;

    srm_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_reg_ram (
        .i_clk   (i_clk),
        .i_we    (reg_we),
        .i_waddr (reg_waddr),
        .i_wdata (reg_wdata),
        .i_raddr (reg_raddr),
        .o_rdata (reg_rdata)
    );

    srm_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_mem_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_opnd[MEM_AW-1:0]),
        .o_rdata (mem_rdata)
    );

    assign in_acc = i_in.valid && i_in.ready;

    always_comb begin
        is_alu   = (r_op == OP_ADD) || (r_op == OP_SUB);
        is_mem   = (r_op == OP_LOAD) || (r_op == OP_STORE);
        rd_bad   = {1'b0, r_rd} >= (REG_IDX_W+1)'(REG_COUNT);
        rs_bad   = {1'b0, r_rs} >= (REG_IDX_W+1)'(REG_COUNT);
        addr_bad = {1'b0, r_opnd} >= (WORD_W+1)'(MEM_WORDS);
        // exact pointer - count, both taken as signed
        disc_diff   = {r_ip[WORD_W-1], r_ip} - {r_opnd[WORD_W-1], r_opnd};
        disc_refuse = r_ip[WORD_W-1] || (r_ip == '0)
                      || (r_ip == {1'b0, {(WORD_W-1){1'b1}}})
                      || disc_diff[WORD_W] || disc_diff[WORD_W-1];
        out_free = !r_out_valid || o_out.ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_clr_resp  <= 1'b0;
            r_ip        <= '0;
            r_running   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_clr_resp  <= n_clr_resp;
            r_ip        <= n_ip;
            r_running   <= n_running;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= t_op'(i_in.op);
            r_rd   <= i_in.reg_dest;
            r_rs   <= i_in.reg_src;
            r_opnd <= i_in.operand;
        end
        r_a          <= n_a;
        r_status     <= n_status;
        r_rval       <= n_rval;
        r_out_status <= n_out_status;
        r_out_rval   <= n_out_rval;
        r_out_ptr    <= n_out_ptr;
        r_out_run    <= n_out_run;
    end

    always_comb begin
        n_state      = r_state;
        n_clr_cnt    = r_clr_cnt;
        n_clr_resp   = r_clr_resp;
        n_ip         = r_ip;
        n_running    = r_running;
        n_a          = r_a;
        n_status     = r_status;
        n_rval       = r_rval;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_rval   = r_out_rval;
        n_out_ptr    = r_out_ptr;
        n_out_run    = r_out_run;

        reg_we    = 1'b0;
        mem_we    = 1'b0;
        reg_waddr = r_rd[REG_AW-1:0];
        reg_wdata = '0;
        reg_raddr = r_rd[REG_AW-1:0];
        mem_waddr = r_opnd[MEM_AW-1:0];
        mem_wdata = r_a;

        // drain the output register when the sink takes the beat
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                // zero one entry of each RAM per cycle
                reg_waddr = r_clr_cnt[REG_AW-1:0];
                mem_waddr = r_clr_cnt[MEM_AW-1:0];
                mem_wdata = '0;
                reg_we    = 32'(r_clr_cnt) < 32'(REG_COUNT);
                mem_we    = 32'(r_clr_cnt) < 32'(MEM_WORDS);
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (r_clr_cnt == CLR_AW'(CLR_DEPTH - 1)) begin
                    n_clr_cnt = '0;
                    n_state   = r_clr_resp ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status = ST_OK;
                n_rval   = '0;
                n_state  = S_DONE;
                priority if (r_op == OP_START) begin
                    n_ip       = WORD_W'(1);
                    n_running  = 1'b1;
                    n_clr_resp = 1'b1;
                    n_state    = S_CLEAR;
                end else if (r_op == OP_EXIT) begin
                    if (r_running) begin
                        n_running  = 1'b0;
                        n_clr_resp = 1'b1;
                        n_state    = S_CLEAR;
                    end else begin
                        n_status = ST_TERMINATE;
                    end
                end else if (!r_running) begin
                    n_status = ST_NOT_STARTED;
                end else if (r_op == OP_DISC) begin
                    if (disc_refuse) begin
                        n_status = ST_DISC_REFUSED;
                    end else begin
                        n_ip = disc_diff[WORD_W-1:0];
                    end
                end else if (rd_bad || (is_alu && rs_bad)) begin
                    n_status = ST_BAD_REG;
                end else if (is_mem && addr_bad) begin
                    n_status = ST_BAD_ADDR;
                end else begin
                    // rd is being read this cycle
                    n_state = S_RD_B;
                end
            end
            S_RD_B: begin
                // hold rd's value, read rs; the memory word follows too
                n_a       = reg_rdata;
                reg_raddr = r_rs[REG_AW-1:0];
                n_state   = S_WB;
            end
            S_WB: begin
                reg_we = 1'b1;
                unique case (r_op)
                    OP_ADD:  reg_wdata = r_a + reg_rdata;
                    OP_SUB:  reg_wdata = r_a - reg_rdata;
                    OP_MOV:  reg_wdata = r_opnd;
                    OP_LOAD: reg_wdata = mem_rdata;
                    default: begin
                        reg_we = 1'b0;
                        mem_we = 1'b1;
                    end
                endcase
                n_rval  = reg_we ? reg_wdata : '0;
                n_ip    = r_ip + 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_rval   = r_rval;
                    n_out_ptr    = r_ip;
                    n_out_run    = r_running;
                    n_clr_resp   = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out_status;
    assign o_out.reg_value  = r_out_rval;
    assign o_out.pointer    = r_out_ptr;
    assign o_out.is_running = r_out_run;

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import srm_pkg::*;

    localparam int REG_N        = REG_COUNT_DEF;
    localparam int MEM_N        = MEM_WORDS_DEF;
    localparam int RANDOM_ITEMS = 500;
    // Longest single instruction is the memory sweep of START / running EXIT.
    localparam int TAIL_CYCLES  = 300;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        t_op                       op;
        logic [REG_IDX_W-1:0]      rd;
        logic [REG_IDX_W-1:0]      rs;
        logic signed [WORD_W-1:0]  operand;
        bit                        drain;   // hold until every result is back
    } t_instr;

    typedef struct {
        t_status                   status;
        logic signed [WORD_W-1:0]  value;
        logic signed [WORD_W-1:0]  ptr;
        logic                      run;
    } t_exec_result;

    logic i_clk;
    logic i_rst_n;

    srm_in_if  instr_ch ();
    srm_out_if result_ch ();

    small_register_machine_executor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (instr_ch),
        .o_out   (result_ch)
    );

    // Shadow copy of the machine, advanced once per accepted instruction beat.
    logic [WORD_W-1:0]        shadow_regs [REG_N];
    logic [WORD_W-1:0]        shadow_mem  [MEM_N];
    logic signed [WORD_W-1:0] shadow_ip;
    logic                     shadow_running;

    t_instr       instr_queue[$];   // instructions still to be driven
    t_exec_result results_due[$];   // predicted results, oldest first

    logic in_beat;                  // instruction beat taken at the last rising edge
    int   burst_left;
    int   gap_left;
    int   stall_mode;
    int   stall_timer;
    int   fail_count;
    int   result_count;
    int   op_count     [8];
    int   status_count [8];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Generous ceiling: far beyond a run made only of memory sweeps and stalls.
    initial begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic void wipe_stores();
        foreach (shadow_regs[k]) shadow_regs[k] = '0;
        foreach (shadow_mem[k])  shadow_mem[k]  = '0;
    endfunction

    // Execute one instruction on the shadow machine and return its result beat.
    function automatic t_exec_result step_machine(input t_instr ins);
        t_exec_result r;
        longint       ptr_wide;
        longint       diff;
        r.status = ST_OK;
        r.value  = '0;
        if (ins.op == OP_START) begin
            wipe_stores();
            shadow_ip      = 1;
            shadow_running = 1'b1;
        end else if (ins.op == OP_EXIT) begin
            // a running machine is cleared but keeps its pointer
            if (shadow_running) begin
                wipe_stores();
                shadow_running = 1'b0;
            end else begin
                r.status = ST_TERMINATE;
            end
        end else if (!shadow_running) begin
            r.status = ST_NOT_STARTED;
        end else if (ins.op == OP_DISC) begin
            // work in 64 bits so the exact difference is seen before wrapping
            ptr_wide = longint'(shadow_ip);
            diff     = ptr_wide - longint'(ins.operand);
            if (ptr_wide <= 0 || ptr_wide == 64'sd2147483647 ||
                    diff < 0 || diff > 64'sd2147483647) begin
                r.status = ST_DISC_REFUSED;
            end else begin
                shadow_ip = WORD_W'(diff);
            end
        end else if (ins.rd >= REG_N ||
                     ((ins.op == OP_ADD || ins.op == OP_SUB) && ins.rs >= REG_N)) begin
            r.status = ST_BAD_REG;
        end else if ((ins.op == OP_LOAD || ins.op == OP_STORE) &&
                     (ins.operand < 0 || ins.operand >= MEM_N)) begin
            r.status = ST_BAD_ADDR;
        end else begin
            case (ins.op)
                OP_ADD: begin
                    shadow_regs[ins.rd] = shadow_regs[ins.rd] + shadow_regs[ins.rs];
                    r.value = shadow_regs[ins.rd];
                end
                OP_SUB: begin
                    shadow_regs[ins.rd] = shadow_regs[ins.rd] - shadow_regs[ins.rs];
                    r.value = shadow_regs[ins.rd];
                end
                OP_MOV: begin
                    shadow_regs[ins.rd] = ins.operand;
                    r.value = ins.operand;
                end
                OP_LOAD: begin
                    shadow_regs[ins.rd] = shadow_mem[ins.operand];
                    r.value = shadow_regs[ins.rd];
                end
                default: begin
                    shadow_mem[ins.operand] = shadow_regs[ins.rd];
                end
            endcase
            // pointer advances with 32-bit wrap
            shadow_ip = shadow_ip + 1;
        end
        r.ptr = shadow_ip;
        r.run = shadow_running;
        return r;
    endfunction

    task automatic push_instr(input t_op op, input int rd, input int rs,
                              input logic [WORD_W-1:0] operand, input bit drain = 1'b0);
        t_instr ins;
        ins.op      = op;
        ins.rd      = rd[REG_IDX_W-1:0];
        ins.rs      = rs[REG_IDX_W-1:0];
        ins.operand = operand;
        ins.drain   = drain;
        instr_queue.push_back(ins);
    endtask

    // Mostly a live register, now and then an index beyond the file.
    function automatic int pick_reg();
        return ($urandom_range(0, 15) == 0) ? $urandom_range(REG_N, 255)
                                            : $urandom_range(0, REG_N - 1);
    endfunction

    // Mostly a narrow window so stores and loads meet, plus edges and junk.
    function automatic logic [WORD_W-1:0] pick_addr();
        case ($urandom_range(0, 15))
            0:       return $urandom;
            1:       return $urandom_range(MEM_N, 1000);
            2:       return MEM_N - 1;
            3:       return $urandom_range(0, MEM_N - 1);
            default: return $urandom_range(0, 7);
        endcase
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // Sender: present instructions in bursts with random gaps. A beat stays on
    // the bus until taken; valid gets exactly one update per falling edge.
    always @(negedge i_clk) begin : drive
        t_instr head;
        logic   nxt_valid;
        // hold valid low until reset is seen released
        nxt_valid = (i_rst_n === 1'b1) ? instr_ch.valid : 1'b0;
        if (i_rst_n && (!instr_ch.valid || in_beat)) begin
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (instr_queue.size() != 0 &&
                         !(instr_queue[0].drain && results_due.size() != 0)) begin
                head = instr_queue.pop_front();
                instr_ch.op       <= head.op;
                instr_ch.reg_dest <= head.rd;
                instr_ch.reg_src  <= head.rs;
                instr_ch.operand  <= head.operand;
                nxt_valid = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
        instr_ch.valid <= nxt_valid;
    end

    // Receiver: change stall behaviour whenever the stall timer runs out.
    always @(negedge i_clk) begin : back_pressure
        logic rdy;
        if (stall_timer == 0) begin
            stall_mode  = $urandom_range(0, 3);
            stall_timer = $urandom_range(20, 80);
        end else begin
            stall_timer--;
        end
        case (stall_mode)
            0:       rdy = 1'b1;
            1:       rdy = $urandom_range(0, 1);
            2:       rdy = ($urandom_range(0, 3) == 0);
            default: rdy = ~result_ch.ready;
        endcase
        result_ch.ready <= rdy;
    end

    // Check result beats first, then predict for the instruction taken at this
    // edge; a result can never belong to the instruction accepted at its own edge.
    always @(posedge i_clk) begin : observe
        t_exec_result want;
        t_instr       got;
        in_beat <= instr_ch.valid && instr_ch.ready;
        if (i_rst_n) begin
            if (result_ch.valid && result_ch.ready) begin
                result_count++;
                if (results_due.size() == 0) begin
                    note_failure($sformatf("result beat with nothing expected: status %0d",
                                           result_ch.status));
                end else begin
                    want = results_due.pop_front();
                    status_count[int'(want.status)]++;
                    if (result_ch.status !== want.status || result_ch.reg_value !== want.value ||
                            result_ch.pointer !== want.ptr ||
                            result_ch.is_running !== want.run) begin
                        note_failure($sformatf(
                            "exp st %0d val %h ptr %h run %0d / got st %0d val %h ptr %h run %0d",
                            want.status, want.value, want.ptr, want.run,
                            result_ch.status, result_ch.reg_value, result_ch.pointer,
                            result_ch.is_running));
                    end
                end
            end
            if (instr_ch.valid && instr_ch.ready) begin
                got.op      = t_op'(instr_ch.op);
                got.rd      = instr_ch.reg_dest;
                got.rs      = instr_ch.reg_src;
                got.operand = instr_ch.operand;
                got.drain   = 1'b0;
                op_count[int'(got.op)]++;
                results_due.push_back(step_machine(got));
            end
        end
    end

    initial begin : run
        int   target;
        int   roll;
        int   k;
        t_op  op_pick;
        logic [WORD_W-1:0] opnd;

        // drive every input to a known level from time zero
        i_rst_n            = 1'b0;
        instr_ch.valid     = 1'b0;
        instr_ch.op        = OP_ADD;
        instr_ch.reg_dest  = '0;
        instr_ch.reg_src   = '0;
        instr_ch.operand   = '0;
        result_ch.ready    = 1'b0;
        in_beat            = 1'b0;
        burst_left         = 1;
        gap_left           = 0;
        stall_mode         = 0;
        stall_timer        = 0;
        fail_count         = 0;
        result_count       = 0;
        foreach (op_count[k])     op_count[k] = 0;
        foreach (status_count[k]) status_count[k] = 0;
        wipe_stores();
        shadow_ip      = '0;
        shadow_running = 1'b0;

        // Directed: stopped machine first
        push_instr(OP_ADD,  0, 0, 0);
        push_instr(OP_EXIT, 0, 0, 0);
        push_instr(OP_DISC, 0, 0, 1);
        // start with all ignored fields high
        push_instr(OP_START, 255, 255, 32'hFFFF_FFFF);
        push_instr(OP_MOV,   0, 0, 32'h7FFF_FFFF);
        push_instr(OP_MOV,   1, 0, 1);
        push_instr(OP_ADD,   0, 1, 0);                  // wraps to most negative
        push_instr(OP_MOV,   7, 0, 32'hFFFF_FFFF);
        push_instr(OP_SUB,   2, 0, 0);                  // zero minus most negative
        push_instr(OP_STORE, 7, 0, MEM_N - 1);
        push_instr(OP_LOAD,  3, 0, MEM_N - 1);          // pointer now 8
        push_instr(OP_STORE, 0, 0, MEM_N);              // address one past the end
        push_instr(OP_LOAD,  0, 0, 32'h8000_0000);      // negative address
        push_instr(OP_MOV,   REG_N, 0, 5);              // register one past the end
        push_instr(OP_ADD,   0, 255, 0);                // bad second register
        push_instr(OP_STORE, 255, 0, 300);              // register checked before address
        push_instr(OP_DISC,  0, 0, 10);                 // difference negative
        push_instr(OP_DISC,  0, 0, 32'h8000_0000);      // difference above the top
        push_instr(OP_DISC,  0, 0, 32'h8000_0009);      // pointer lands on the top value
        push_instr(OP_DISC,  0, 0, 0);                  // refused at the top value
        push_instr(OP_MOV,   5, 0, 123);                // pointer wraps negative
        push_instr(OP_DISC,  0, 0, 0);                  // refused on a negative pointer
        push_instr(OP_START, 0, 0, 0);                  // restart while running
        push_instr(OP_DISC,  0, 0, 1);                  // pointer to zero
        push_instr(OP_DISC,  0, 0, 32'hFFFF_FFFF);      // refused on a zero pointer
        push_instr(OP_MOV,   6, 0, 42);
        push_instr(OP_STORE, 6, 0, 17);
        push_instr(OP_EXIT,  0, 0, 0, 1'b1);            // pause the sender before it
        push_instr(OP_LOAD,  1, 0, 17);                 // stopped again
        push_instr(OP_START, 0, 0, 0);
        push_instr(OP_LOAD,  1, 0, 17);                 // memory was cleared

        // Random: mostly well-formed programmes on a running machine
        target = instr_queue.size() + RANDOM_ITEMS;
        push_instr(OP_START, pick_reg(), pick_reg(), $urandom, 1'b1);
        while (instr_queue.size() < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                // noise: any field at any value
                op_pick = t_op'($urandom_range(0, 7));
                push_instr(op_pick, $urandom_range(0, 255), $urandom_range(0, 255), $urandom);
                if (op_pick == OP_EXIT)
                    push_instr(OP_START, 0, 0, 0);
            end else if (roll < 11) begin
                push_instr(OP_START, pick_reg(), pick_reg(), $urandom);
            end else if (roll < 14) begin
                // stop, poke the stopped machine a little, start again
                push_instr(OP_EXIT, pick_reg(), pick_reg(), $urandom);
                for (k = $urandom_range(0, 2); k > 0; k--)
                    push_instr(t_op'($urandom_range(0, 7)), pick_reg(), pick_reg(), pick_addr());
                push_instr(OP_START, 0, 0, 0);
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 18)      op_pick = OP_ADD;
                else if (roll < 34) op_pick = OP_SUB;
                else if (roll < 54) op_pick = OP_MOV;
                else if (roll < 70) op_pick = OP_LOAD;
                else if (roll < 86) op_pick = OP_STORE;
                else                op_pick = OP_DISC;
                case (op_pick)
                    OP_MOV: begin
                        case ($urandom_range(0, 3))
                            0:       opnd = $urandom_range(0, 15);
                            1:       opnd = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF
                                                                         : 32'h8000_0000;
                            default: opnd = $urandom;
                        endcase
                    end
                    OP_LOAD, OP_STORE: opnd = pick_addr();
                    OP_DISC: begin
                        roll = $urandom_range(0, 9);
                        if (roll < 6)       opnd = $urandom_range(0, 3);
                        else if (roll < 8)  opnd = -$urandom_range(1, 4);
                        else if (roll == 8) opnd = $urandom;
                        else                opnd = 32'h7FFF_FFFF;
                    end
                    default: opnd = $urandom;
                endcase
                push_instr(op_pick, pick_reg(), pick_reg(), opnd,
                           (instr_queue.size() % 150) == 0);
            end
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // drain: every beat sent, every result back, then a quiet tail
        while (instr_queue.size() != 0 || instr_ch.valid) @(negedge i_clk);
        while (results_due.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d instructions (%0d start, %0d exit, %0d discard), checked %0d results.",
                 op_count[OP_ADD] + op_count[OP_SUB] + op_count[OP_MOV] + op_count[OP_LOAD] +
                 op_count[OP_STORE] + op_count[OP_START] + op_count[OP_EXIT] +
                 op_count[OP_DISC], op_count[OP_START], op_count[OP_EXIT],
                 op_count[OP_DISC], result_count);
        $display("Outcomes: ok %0d, stopped %0d, bad reg %0d, bad addr %0d, refused %0d, term %0d.",
                 status_count[ST_OK], status_count[ST_NOT_STARTED], status_count[ST_BAD_REG],
                 status_count[ST_BAD_ADDR], status_count[ST_DISC_REFUSED],
                 status_count[ST_TERMINATE]);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches in total", fail_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### filelist.f
src/srm_pkg.sv
src/srm_in_if.sv
src/srm_out_if.sv
src/srm_ram.sv
src/small_register_machine_executor.sv
test/testbench.sv
